[rtl/cfcr_pkg.sv]
package cfcr_pkg;

   // Field widths
   localparam int COORD_W  = 12;
   localparam int RAD_W    = 10;
   localparam int LAYER_W  = 4;
   localparam int GLYPH_W  = 8;
   localparam int COLOR_W  = 16;
   localparam int ADDR_W   = 20;
   localparam int DIMREG_W = 9;
   localparam int CSR_IDX_W = 1;

   // Signed width for the clip math: center +/- radius + 1 never leaves 13 bits
   localparam int CLIP_W = 13;
   // Squared distances and radius squared: 10-bit magnitudes squared
   localparam int SQ_W   = 2 * RAD_W;
   // Raw width times raw height
   localparam int AREA_W = 2 * DIMREG_W;

   localparam int MAX_DIM_DEF    = 256;
   localparam int MAX_LAYERS_DEF = 16;

   localparam logic [DIMREG_W-1:0] DIM_RESET = 9'd64;

   // Command codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SPRITE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPRITE_HEIGHT = 1'b1;

   // hit: pixel step on a live scan, may write; last: done flag of the word
   typedef struct packed {
      logic hit;
      logic last;
   } stage_ctl_type;

endpackage

[rtl/cfcr_csr.sv]
module cfcr_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [cfcr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cfcr_pkg::DIMREG_W-1:0]     csr_wdata,
   output logic [cfcr_pkg::DIMREG_W-1:0]     sprite_width,
   output logic [cfcr_pkg::DIMREG_W-1:0]     sprite_height,
   output logic [cfcr_pkg::AREA_W-1:0]       sprite_area
);
   import cfcr_pkg::*;

   logic [DIMREG_W-1:0] width_ff, width_in;
   logic [DIMREG_W-1:0] height_ff, height_in;
   logic [AREA_W-1:0]   area_ff, area_in;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SPRITE_WIDTH:  width_in  = csr_wdata;
            CSR_SPRITE_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
      // layer stride, registered from the width and height registers
      area_in = {{(AREA_W-DIMREG_W){1'b0}}, width_ff} *
                {{(AREA_W-DIMREG_W){1'b0}}, height_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
      area_ff <= area_in;
   end

   assign sprite_width  = width_ff;
   assign sprite_height = height_ff;
   assign sprite_area   = area_ff;

endmodule

[rtl/cfcr_scan.sv]
module cfcr_scan #(
   parameter int MAX_DIM    = cfcr_pkg::MAX_DIM_DEF,
   parameter int MAX_LAYERS = cfcr_pkg::MAX_LAYERS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_cmd,
   input  logic signed [cfcr_pkg::COORD_W-1:0]    req_center_x,
   input  logic signed [cfcr_pkg::COORD_W-1:0]    req_center_y,
   input  logic [cfcr_pkg::LAYER_W-1:0]           req_layer,
   input  logic [cfcr_pkg::RAD_W-1:0]             req_radius,
   input  logic [cfcr_pkg::GLYPH_W-1:0]           req_glyph_in,
   input  logic [cfcr_pkg::COLOR_W-1:0]           req_color_in,
   input  logic [cfcr_pkg::DIMREG_W-1:0]          sprite_width,
   input  logic [cfcr_pkg::DIMREG_W-1:0]          sprite_height,
   output logic                                   s1_valid,
   input  logic                                   s1_ready,
   output cfcr_pkg::stage_ctl_type                s1_ctl,
   output logic [$clog2(MAX_DIM+1)-1:0]           s1_col,
   output logic [$clog2(MAX_DIM+1)-1:0]           s1_row,
   output logic [cfcr_pkg::RAD_W-1:0]             s1_adx,
   output logic [cfcr_pkg::RAD_W-1:0]             s1_ady,
   output logic [cfcr_pkg::RAD_W-1:0]             s1_radius,
   output logic [cfcr_pkg::LAYER_W-1:0]           s1_layer,
   output logic [cfcr_pkg::GLYPH_W-1:0]           s1_glyph,
   output logic [cfcr_pkg::COLOR_W-1:0]           s1_color
);
   import cfcr_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 1);

   // scan state
   logic                      busy_ff, busy_in;
   logic [DIM_W-1:0]          col_ff, col_in;
   logic [DIM_W-1:0]          row_ff, row_in;
   logic [DIM_W-1:0]          col_first_ff, col_first_in;
   logic [DIM_W-1:0]          col_limit_ff, col_limit_in;
   logic [DIM_W-1:0]          row_limit_ff, row_limit_in;
   logic signed [COORD_W-1:0] cx_ff, cx_in;
   logic signed [COORD_W-1:0] cy_ff, cy_in;
   logic [RAD_W-1:0]          rad_ff, rad_in;
   logic [LAYER_W-1:0]        layer_ff, layer_in;
   logic [GLYPH_W-1:0]        glyph_ff, glyph_in;
   logic [COLOR_W-1:0]        color_ff, color_in;

   // output stage
   logic                      s1_valid_ff, s1_valid_in;
   stage_ctl_type             s1_ctl_ff, s1_ctl_in;
   logic [DIM_W-1:0]          s1_col_ff, s1_row_ff;
   logic [RAD_W-1:0]          s1_adx_ff, s1_adx_in, s1_ady_ff, s1_ady_in;
   logic [RAD_W-1:0]          s1_radius_ff;
   logic [LAYER_W-1:0]        s1_layer_ff;
   logic [GLYPH_W-1:0]        s1_glyph_ff;
   logic [COLOR_W-1:0]        s1_color_ff;

   logic                      accept;

   // clip math for a start word
   logic signed [CLIP_W-1:0]  cx_ext, cy_ext, rad_ext, w_ext, h_ext, w_eff, h_eff;
   logic signed [CLIP_W-1:0]  row_lo, row_hi, col_lo, col_hi;
   logic signed [CLIP_W-1:0]  row_first, col_first, row_end_c, col_end_c;
   logic signed [CLIP_W-1:0]  row_end, col_end;
   logic                      start_busy;
   logic [LAYER_W-1:0]        layer_sat;

   // step math
   logic signed [CLIP_W-1:0]  col_ext, row_ext, hcx_ext, hcy_ext, dx, dy, adx, ady;
   logic [DIM_W:0]            col_inc, row_inc, row_adv;
   logic                      wrap, last;

   assign accept    = req_valid && req_ready;
   assign req_ready = !s1_valid_ff || s1_ready;

   always_comb begin
      cx_ext  = {{(CLIP_W-COORD_W){req_center_x[COORD_W-1]}}, req_center_x};
      cy_ext  = {{(CLIP_W-COORD_W){req_center_y[COORD_W-1]}}, req_center_y};
      rad_ext = {{(CLIP_W-RAD_W){1'b0}}, req_radius};
      w_ext   = {{(CLIP_W-DIMREG_W){1'b0}}, sprite_width};
      h_ext   = {{(CLIP_W-DIMREG_W){1'b0}}, sprite_height};
      w_eff   = (w_ext > CLIP_W'(MAX_DIM)) ? CLIP_W'(MAX_DIM) : w_ext;
      h_eff   = (h_ext > CLIP_W'(MAX_DIM)) ? CLIP_W'(MAX_DIM) : h_ext;

      row_lo    = cy_ext - rad_ext;
      row_hi    = cy_ext + rad_ext + CLIP_W'(1);
      col_lo    = cx_ext - rad_ext;
      col_hi    = cx_ext + rad_ext + CLIP_W'(1);
      row_first = row_lo[CLIP_W-1] ? '0 : row_lo;
      col_first = col_lo[CLIP_W-1] ? '0 : col_lo;
      row_end_c = (row_hi > h_eff) ? h_eff : row_hi;
      col_end_c = (col_hi > w_eff) ? w_eff : col_hi;
      row_end   = row_end_c[CLIP_W-1] ? '0 : row_end_c;
      col_end   = col_end_c[CLIP_W-1] ? '0 : col_end_c;
      start_busy = (row_first < row_end) && (col_first < col_end);

      layer_sat = (int'(req_layer) > MAX_LAYERS - 1) ? LAYER_W'(MAX_LAYERS - 1)
                                                      : req_layer;

      // distance from the center; inside a live box it never exceeds the radius
      col_ext = {{(CLIP_W-DIM_W){1'b0}}, col_ff};
      row_ext = {{(CLIP_W-DIM_W){1'b0}}, row_ff};
      hcx_ext = {{(CLIP_W-COORD_W){cx_ff[COORD_W-1]}}, cx_ff};
      hcy_ext = {{(CLIP_W-COORD_W){cy_ff[COORD_W-1]}}, cy_ff};
      dx      = col_ext - hcx_ext;
      dy      = row_ext - hcy_ext;
      adx     = dx[CLIP_W-1] ? -dx : dx;
      ady     = dy[CLIP_W-1] ? -dy : dy;

      col_inc = {1'b0, col_ff} + (DIM_W+1)'(1);
      row_inc = {1'b0, row_ff} + (DIM_W+1)'(1);
      wrap    = col_inc >= {1'b0, col_limit_ff};
      row_adv = wrap ? row_inc : {1'b0, row_ff};
      last    = row_adv >= {1'b0, row_limit_ff};
   end

   always_comb begin
      busy_in      = busy_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      col_first_in = col_first_ff;
      col_limit_in = col_limit_ff;
      row_limit_in = row_limit_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      rad_in       = rad_ff;
      layer_in     = layer_ff;
      glyph_in     = glyph_ff;
      color_in     = color_ff;
      s1_ctl_in    = s1_ctl_ff;
      s1_adx_in    = adx[RAD_W-1:0];
      s1_ady_in    = ady[RAD_W-1:0];
      s1_valid_in  = s1_ready ? 1'b0 : s1_valid_ff;

      if (accept) begin
         s1_valid_in = 1'b1;
         case (req_cmd)
            CMD_START: begin
               busy_in        = start_busy;
               cx_in          = req_center_x;
               cy_in          = req_center_y;
               rad_in         = req_radius;
               layer_in       = layer_sat;
               glyph_in       = req_glyph_in;
               color_in       = req_color_in;
               col_in         = col_first[DIM_W-1:0];
               row_in         = row_first[DIM_W-1:0];
               col_first_in   = col_first[DIM_W-1:0];
               col_limit_in   = col_end[DIM_W-1:0];
               row_limit_in   = row_end[DIM_W-1:0];
               s1_ctl_in.hit  = 1'b0;
               s1_ctl_in.last = !start_busy;
            end
            CMD_STEP: begin
               s1_ctl_in.hit  = busy_ff;
               s1_ctl_in.last = busy_ff ? last : 1'b1;
               if (busy_ff) begin
                  col_in  = wrap ? col_first_ff : col_inc[DIM_W-1:0];
                  row_in  = row_adv[DIM_W-1:0];
                  busy_in = !last;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         s1_valid_ff <= s1_valid_in;
      end
      col_ff       <= col_in;
      row_ff       <= row_in;
      col_first_ff <= col_first_in;
      col_limit_ff <= col_limit_in;
      row_limit_ff <= row_limit_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      rad_ff       <= rad_in;
      layer_ff     <= layer_in;
      glyph_ff     <= glyph_in;
      color_ff     <= color_in;
      // snapshot the pixel being visited before the counters move
      if (accept) begin
         s1_ctl_ff    <= s1_ctl_in;
         s1_col_ff    <= col_ff;
         s1_row_ff    <= row_ff;
         s1_adx_ff    <= s1_adx_in;
         s1_ady_ff    <= s1_ady_in;
         s1_radius_ff <= rad_ff;
         s1_layer_ff  <= layer_ff;
         s1_glyph_ff  <= glyph_ff;
         s1_color_ff  <= color_ff;
      end
   end

   assign s1_valid  = s1_valid_ff;
   assign s1_ctl    = s1_ctl_ff;
   assign s1_col    = s1_col_ff;
   assign s1_row    = s1_row_ff;
   assign s1_adx    = s1_adx_ff;
   assign s1_ady    = s1_ady_ff;
   assign s1_radius = s1_radius_ff;
   assign s1_layer  = s1_layer_ff;
   assign s1_glyph  = s1_glyph_ff;
   assign s1_color  = s1_color_ff;

`ifndef SYNTH
   a_row_in_box: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (row_ff < row_limit_ff))
      else $error("scan row outside clipped box while busy");

   a_col_in_box: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> ((col_ff < col_limit_ff) && (col_first_ff <= col_ff)))
      else $error("scan column outside clipped box while busy");

   a_idle_step: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd == CMD_STEP) && !busy_ff) |=> !busy_ff)
      else $error("step on idle engine started a scan");

   a_start_done: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd == CMD_START)) |=> (busy_ff == !s1_ctl_ff.last))
      else $error("start done flag disagrees with busy");
`endif

endmodule

[rtl/cfcr_pixel.sv]
module cfcr_pixel #(
   parameter int MAX_DIM = cfcr_pkg::MAX_DIM_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                s1_valid,
   output logic                                s1_ready,
   input  cfcr_pkg::stage_ctl_type             s1_ctl,
   input  logic [$clog2(MAX_DIM+1)-1:0]        s1_col,
   input  logic [$clog2(MAX_DIM+1)-1:0]        s1_row,
   input  logic [cfcr_pkg::RAD_W-1:0]          s1_adx,
   input  logic [cfcr_pkg::RAD_W-1:0]          s1_ady,
   input  logic [cfcr_pkg::RAD_W-1:0]          s1_radius,
   input  logic [cfcr_pkg::LAYER_W-1:0]        s1_layer,
   input  logic [cfcr_pkg::GLYPH_W-1:0]        s1_glyph,
   input  logic [cfcr_pkg::COLOR_W-1:0]        s1_color,
   input  logic [cfcr_pkg::DIMREG_W-1:0]       sprite_width,
   input  logic [cfcr_pkg::AREA_W-1:0]         sprite_area,
   output logic                                s2_valid,
   input  logic                                s2_ready,
   output cfcr_pkg::stage_ctl_type             s2_ctl,
   output logic [$clog2(MAX_DIM+1)-1:0]        s2_col,
   output logic [cfcr_pkg::SQ_W-1:0]           s2_dsq_x,
   output logic [cfcr_pkg::SQ_W-1:0]           s2_dsq_y,
   output logic [cfcr_pkg::SQ_W-1:0]           s2_rr,
   output logic [cfcr_pkg::ADDR_W-1:0]         s2_row_off,
   output logic [cfcr_pkg::ADDR_W-1:0]         s2_layer_off,
   output logic [cfcr_pkg::GLYPH_W-1:0]        s2_glyph,
   output logic [cfcr_pkg::COLOR_W-1:0]        s2_color
);
   import cfcr_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 1);

   logic                 valid_ff, valid_in;
   logic                 load;
   stage_ctl_type        ctl_ff;
   logic [DIM_W-1:0]     col_ff;
   logic [SQ_W-1:0]      dsq_x_ff, dsq_x_in, dsq_y_ff, dsq_y_in, rr_ff, rr_in;
   logic [ADDR_W-1:0]    row_off_ff, row_off_in, layer_off_ff, layer_off_in;
   logic [GLYPH_W-1:0]   glyph_ff;
   logic [COLOR_W-1:0]   color_ff;

   assign s1_ready = !valid_ff || s2_ready;
   assign load     = s1_valid && s1_ready;

   always_comb begin
      valid_in = load ? 1'b1 : (s2_ready ? 1'b0 : valid_ff);
      dsq_x_in = {{RAD_W{1'b0}}, s1_adx} * {{RAD_W{1'b0}}, s1_adx};
      dsq_y_in = {{RAD_W{1'b0}}, s1_ady} * {{RAD_W{1'b0}}, s1_ady};
      rr_in    = {{RAD_W{1'b0}}, s1_radius} * {{RAD_W{1'b0}}, s1_radius};
      row_off_in   = {{(ADDR_W-DIM_W){1'b0}}, s1_row} *
                     {{(ADDR_W-DIMREG_W){1'b0}}, sprite_width};
      // wraps to the address width like the address itself
      layer_off_in = {{(ADDR_W-LAYER_W){1'b0}}, s1_layer} *
                     {{(ADDR_W-AREA_W){1'b0}}, sprite_area};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         ctl_ff       <= s1_ctl;
         col_ff       <= s1_col;
         dsq_x_ff     <= dsq_x_in;
         dsq_y_ff     <= dsq_y_in;
         rr_ff        <= rr_in;
         row_off_ff   <= row_off_in;
         layer_off_ff <= layer_off_in;
         glyph_ff     <= s1_glyph;
         color_ff     <= s1_color;
      end
   end

   assign s2_valid     = valid_ff;
   assign s2_ctl       = ctl_ff;
   assign s2_col       = col_ff;
   assign s2_dsq_x     = dsq_x_ff;
   assign s2_dsq_y     = dsq_y_ff;
   assign s2_rr        = rr_ff;
   assign s2_row_off   = row_off_ff;
   assign s2_layer_off = layer_off_ff;
   assign s2_glyph     = glyph_ff;
   assign s2_color     = color_ff;

endmodule

[rtl/cfcr_emit.sv]
module cfcr_emit #(
   parameter int MAX_DIM = cfcr_pkg::MAX_DIM_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                s2_valid,
   output logic                                s2_ready,
   input  cfcr_pkg::stage_ctl_type             s2_ctl,
   input  logic [$clog2(MAX_DIM+1)-1:0]        s2_col,
   input  logic [cfcr_pkg::SQ_W-1:0]           s2_dsq_x,
   input  logic [cfcr_pkg::SQ_W-1:0]           s2_dsq_y,
   input  logic [cfcr_pkg::SQ_W-1:0]           s2_rr,
   input  logic [cfcr_pkg::ADDR_W-1:0]         s2_row_off,
   input  logic [cfcr_pkg::ADDR_W-1:0]         s2_layer_off,
   input  logic [cfcr_pkg::GLYPH_W-1:0]        s2_glyph,
   input  logic [cfcr_pkg::COLOR_W-1:0]        s2_color,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_write_valid,
   output logic [cfcr_pkg::ADDR_W-1:0]         rsp_address,
   output logic [cfcr_pkg::GLYPH_W-1:0]        rsp_glyph_out,
   output logic [cfcr_pkg::COLOR_W-1:0]        rsp_color_out,
   output logic                                rsp_done_res
);
   import cfcr_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 1);

   logic                 valid_ff, valid_in;
   logic                 load;
   logic                 in_disk, write_in;
   logic [SQ_W:0]        dist_sq;
   logic [ADDR_W-1:0]    addr_sum;
   logic                 write_ff, done_ff;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [GLYPH_W-1:0]   glyph_ff, glyph_in;
   logic [COLOR_W-1:0]   color_ff, color_in;

   assign s2_ready = !valid_ff || rsp_ready;
   assign load     = s2_valid && s2_ready;

   always_comb begin
      valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
      dist_sq  = {1'b0, s2_dsq_x} + {1'b0, s2_dsq_y};
      in_disk  = dist_sq <= {1'b0, s2_rr};
      addr_sum = {{(ADDR_W-DIM_W){1'b0}}, s2_col} + s2_row_off + s2_layer_off;
      write_in = s2_ctl.hit && in_disk;
      // zero the payload of a word that writes nothing
      addr_in  = write_in ? addr_sum : '0;
      glyph_in = write_in ? s2_glyph : '0;
      color_in = write_in ? s2_color : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         write_ff <= write_in;
         done_ff  <= s2_ctl.last;
         addr_ff  <= addr_in;
         glyph_ff <= glyph_in;
         color_ff <= color_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_write_valid = write_ff;
   assign rsp_address     = addr_ff;
   assign rsp_glyph_out   = glyph_ff;
   assign rsp_color_out   = color_ff;
   assign rsp_done_res    = done_ff;

endmodule

[rtl/clipped_filled_circle_raster_core.sv]
// Filled-circle rasterizer for a layered character sprite. A start word (cmd 0)
// latches center, radius, layer, glyph and color, clips the circle's bounding
// box to the sprite and answers with one response carrying done_res set when
// the clipped box is empty. Each step word (cmd 1) visits the next pixel of the
// box in row-major order and answers with one response: a write of glyph and
// color at col + row*width + layer*width*height when the pixel lies within the
// radius, done_res on the last pixel, and done_res alone for a step while idle.
// The core takes one word per clock and returns one response per clock while
// rsp_ready is high; a response passes three registers: the scan stage, the
// multiplier stage (squares, row and layer offsets) and the compare/address
// output register. Backpressure on rsp_ready stalls the whole pipeline. The
// layer stride width*height is registered from the two sprite registers, so it
// reflects a register write one register after width and height do.
module clipped_filled_circle_raster_core #(
   parameter int MAX_DIM    = cfcr_pkg::MAX_DIM_DEF,
   parameter int MAX_LAYERS = cfcr_pkg::MAX_LAYERS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic signed [cfcr_pkg::COORD_W-1:0] req_center_x,
   input  logic signed [cfcr_pkg::COORD_W-1:0] req_center_y,
   input  logic [cfcr_pkg::LAYER_W-1:0]        req_layer,
   input  logic [cfcr_pkg::RAD_W-1:0]          req_radius,
   input  logic [cfcr_pkg::GLYPH_W-1:0]        req_glyph_in,
   input  logic [cfcr_pkg::COLOR_W-1:0]        req_color_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_write_valid,
   output logic [cfcr_pkg::ADDR_W-1:0]         rsp_address,
   output logic [cfcr_pkg::GLYPH_W-1:0]        rsp_glyph_out,
   output logic [cfcr_pkg::COLOR_W-1:0]        rsp_color_out,
   output logic                                rsp_done_res,
   input  logic                                csr_wr_en,
   input  logic [cfcr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cfcr_pkg::DIMREG_W-1:0]       csr_wdata
);
   import cfcr_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 1);

   logic [DIMREG_W-1:0] sprite_width, sprite_height;
   logic [AREA_W-1:0]   sprite_area;

   logic                s1_valid, s1_ready;
   stage_ctl_type       s1_ctl;
   logic [DIM_W-1:0]    s1_col, s1_row;
   logic [RAD_W-1:0]    s1_adx, s1_ady, s1_radius;
   logic [LAYER_W-1:0]  s1_layer;
   logic [GLYPH_W-1:0]  s1_glyph;
   logic [COLOR_W-1:0]  s1_color;

   logic                s2_valid, s2_ready;
   stage_ctl_type       s2_ctl;
   logic [DIM_W-1:0]    s2_col;
   logic [SQ_W-1:0]     s2_dsq_x, s2_dsq_y, s2_rr;
   logic [ADDR_W-1:0]   s2_row_off, s2_layer_off;
   logic [GLYPH_W-1:0]  s2_glyph;
   logic [COLOR_W-1:0]  s2_color;

   cfcr_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .sprite_width  (sprite_width),
      .sprite_height (sprite_height),
      .sprite_area   (sprite_area)
   );

   cfcr_scan #(
      .MAX_DIM    (MAX_DIM),
      .MAX_LAYERS (MAX_LAYERS)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_center_x  (req_center_x),
      .req_center_y  (req_center_y),
      .req_layer     (req_layer),
      .req_radius    (req_radius),
      .req_glyph_in  (req_glyph_in),
      .req_color_in  (req_color_in),
      .sprite_width  (sprite_width),
      .sprite_height (sprite_height),
      .s1_valid      (s1_valid),
      .s1_ready      (s1_ready),
      .s1_ctl        (s1_ctl),
      .s1_col        (s1_col),
      .s1_row        (s1_row),
      .s1_adx        (s1_adx),
      .s1_ady        (s1_ady),
      .s1_radius     (s1_radius),
      .s1_layer      (s1_layer),
      .s1_glyph      (s1_glyph),
      .s1_color      (s1_color)
   );

   cfcr_pixel #(
      .MAX_DIM (MAX_DIM)
   ) u_pixel (
      .clock        (clock),
      .reset        (reset),
      .s1_valid     (s1_valid),
      .s1_ready     (s1_ready),
      .s1_ctl       (s1_ctl),
      .s1_col       (s1_col),
      .s1_row       (s1_row),
      .s1_adx       (s1_adx),
      .s1_ady       (s1_ady),
      .s1_radius    (s1_radius),
      .s1_layer     (s1_layer),
      .s1_glyph     (s1_glyph),
      .s1_color     (s1_color),
      .sprite_width (sprite_width),
      .sprite_area  (sprite_area),
      .s2_valid     (s2_valid),
      .s2_ready     (s2_ready),
      .s2_ctl       (s2_ctl),
      .s2_col       (s2_col),
      .s2_dsq_x     (s2_dsq_x),
      .s2_dsq_y     (s2_dsq_y),
      .s2_rr        (s2_rr),
      .s2_row_off   (s2_row_off),
      .s2_layer_off (s2_layer_off),
      .s2_glyph     (s2_glyph),
      .s2_color     (s2_color)
   );

   cfcr_emit #(
      .MAX_DIM (MAX_DIM)
   ) u_emit (
      .clock           (clock),
      .reset           (reset),
      .s2_valid        (s2_valid),
      .s2_ready        (s2_ready),
      .s2_ctl          (s2_ctl),
      .s2_col          (s2_col),
      .s2_dsq_x        (s2_dsq_x),
      .s2_dsq_y        (s2_dsq_y),
      .s2_rr           (s2_rr),
      .s2_row_off      (s2_row_off),
      .s2_layer_off    (s2_layer_off),
      .s2_glyph        (s2_glyph),
      .s2_color        (s2_color),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_write_valid (rsp_write_valid),
      .rsp_address     (rsp_address),
      .rsp_glyph_out   (rsp_glyph_out),
      .rsp_color_out   (rsp_color_out),
      .rsp_done_res    (rsp_done_res)
   );

endmodule
